@@ rtl/core/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, codes and helpers of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int TOTAL_PAGES_DEF = 1024;
  localparam int WORD_BITS       = 32;
  localparam int WORD_SHIFT      = 5;

  localparam logic [10:0] ACTIVE_PAGES_RST = 11'd1024;

  // request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // response codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

  typedef struct packed {
    logic        func;
    logic [9:0]  page_index;
    logic [10:0] page_count;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] start_page;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SRD,
    ST_SCAN,
    ST_SEL,
    ST_MRD,
    ST_MOP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_CHECK,
    PH_SET,
    PH_CLEAR
  } phase_t;

  // lowest set bit: {found, index}
  function automatic logic [WORD_SHIFT:0] ffs32(input logic [WORD_BITS-1:0] v);
    logic [WORD_SHIFT:0] r;
    r = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (v[j]) begin
        r = {1'b1, WORD_SHIFT'(j)};
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/pba_ram.sv @@
// ----------------------------------------------------------------------------
// pba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/page_bitmap_best_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// page_bitmap_best_fit_allocator
// Best-fit allocator of contiguous page runs over a bitmap of used pages.
// ----------------------------------------------------------------------------
// after reset a clearing pass zeroes the map, one word a cycle; requests
//   wait, config writes are taken
// allocate: reads each map word below active_pages, searching used/free
//   boundaries and comparing runs in the scan unit, then marks the chosen run
// free: checks that every page of the range is in use, then clears it word by word
// one request at a time; a finished response waits in the output register
// ----------------------------------------------------------------------------
module page_bitmap_best_fit_allocator
  import pba_pkg::*;
#(
  parameter int TOTAL_PAGES = TOTAL_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: active_pages
  input  logic        cfg_write,
  input  logic [10:0] cfg_data,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  localparam int WORDS  = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  // page pointers hold sums of page and count without wrapping
  localparam int PCW    = ($clog2(TOTAL_PAGES) + 2 > 12) ? $clog2(TOTAL_PAGES) + 2 : 12;

  // control state
  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [AW-1:0]     clr_cnt, clr_cnt_next;
  logic [10:0]       active_pages;
  rsp_t              rsp_next;
  logic              rsp_valid_next;

  // working registers of the current request
  logic              func_r, func_next;
  logic [PCW-1:0]    pos, pos_next;          // current page
  logic [PCW-1:0]    run, run_next;          // length of free run so far
  logic [PCW-1:0]    best_len, best_len_next;
  logic              found, found_next;
  logic [PCW-1:0]    base, base_next;        // chosen start page / free start
  logic [PCW-1:0]    want, want_next;
  logic [PCW-1:0]    limit, limit_next;      // pages scanned
  logic [PCW-1:0]    end_page, end_page_next;
  logic              seek_used, seek_used_next; // inside a free run
  logic [1:0]        res_status, res_status_next;
  logic [9:0]        res_start, res_start_next;

  // map memory
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         word_addr;
  logic [WORD_BITS-1:0]  ram_rdata;

  // shared scan unit
  logic [PCW-1:0]        word_base;
  logic [WORD_SHIFT-1:0] bit_off;
  logic [PCW-1:0]        next_word;
  logic [PCW-1:0]        lim_off;
  logic [PCW-1:0]        end_off;
  logic [WORD_BITS-1:0]  low_mask;
  logic [WORD_BITS-1:0]  hi_used;
  logic [WORD_BITS-1:0]  eff_word;
  logic [WORD_BITS-1:0]  rng_hi;
  logic [WORD_BITS-1:0]  rng_mask;
  logic [WORD_SHIFT:0]   used_hit;
  logic [WORD_SHIFT:0]   free_hit;
  logic [PCW-1:0]        run_eval;
  logic [PCW-1:0]        evt_page;
  logic [PCW-1:0]        run_start;
  logic                  exact;
  logic                  better;

  pba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(word_addr),
    .rdata(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // scan unit: one map word, one boundary search and one run compare a cycle
  // ---------------------------------------------------------------------------
  assign word_base = pos & ~PCW'(WORD_BITS - 1);
  assign bit_off   = pos[WORD_SHIFT-1:0];
  assign next_word = word_base + PCW'(WORD_BITS);
  assign word_addr = AW'(pos >> WORD_SHIFT);
  assign lim_off   = limit - word_base;
  assign end_off   = end_page - word_base;
  assign low_mask  = '1 << bit_off;

  always_comb begin
    // pages at or past the scan limit look used, so they close the last run
    if (limit >= next_word) begin
      hi_used = '0;
    end else begin
      hi_used = ~((WORD_BITS'(1) << lim_off[WORD_SHIFT-1:0]) - WORD_BITS'(1));
    end
    if (end_page >= next_word) begin
      rng_hi = '1;
    end else begin
      rng_hi = (WORD_BITS'(1) << end_off[WORD_SHIFT-1:0]) - WORD_BITS'(1);
    end
  end

  assign eff_word = ram_rdata | hi_used;
  assign rng_mask = low_mask & rng_hi;
  assign used_hit = ffs32(eff_word & low_mask);
  assign free_hit = ffs32(~eff_word & low_mask);

  // a run closes either at a used page in the word or at the limit itself
  assign run_eval  = (state == ST_SCAN)
                   ? run + PCW'(used_hit[WORD_SHIFT-1:0]) - PCW'(bit_off)
                   : run;
  assign evt_page  = (state == ST_SCAN)
                   ? word_base + PCW'(used_hit[WORD_SHIFT-1:0])
                   : limit;
  assign run_start = evt_page - run_eval;
  assign exact     = (run_eval == want);
  assign better    = (run_eval >= want) && (run_eval < best_len);

  assign req_stall = (state != ST_IDLE);

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR;
      clr_cnt      <= '0;
      rsp_valid    <= 1'b0;
      active_pages <= ACTIVE_PAGES_RST;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_write) begin
        active_pages <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase      <= phase_next;
    rsp        <= rsp_next;
    func_r     <= func_next;
    pos        <= pos_next;
    run        <= run_next;
    best_len   <= best_len_next;
    found      <= found_next;
    base       <= base_next;
    want       <= want_next;
    limit      <= limit_next;
    end_page   <= end_page_next;
    seek_used  <= seek_used_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    clr_cnt_next    = clr_cnt;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid;
    func_next       = func_r;
    pos_next        = pos;
    run_next        = run;
    best_len_next   = best_len;
    found_next      = found;
    base_next       = base;
    want_next       = want;
    limit_next      = limit;
    end_page_next   = end_page;
    seek_used_next  = seek_used;
    res_status_next = res_status;
    res_start_next  = res_start;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = word_addr;
    ram_wdata       = '0;

    // response taken downstream
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        if (clr_cnt == AW'(WORDS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + AW'(1);
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          func_next       = req.func;
          want_next       = PCW'(req.page_count);
          limit_next      = (PCW'(active_pages) > PCW'(TOTAL_PAGES))
                          ? PCW'(TOTAL_PAGES) : PCW'(active_pages);
          run_next        = '0;
          best_len_next   = '1;
          found_next      = 1'b0;
          seek_used_next  = 1'b1;
          res_start_next  = '0;
          if (req.func == FUNC_ALLOC) begin
            pos_next = '0;
            if (req.page_count == '0) begin
              res_status_next = STATUS_NO_SPACE;
              state_next      = ST_DONE;
            end else begin
              state_next = ST_SRD;
            end
          end else begin
            base_next     = PCW'(req.page_index);
            pos_next      = PCW'(req.page_index);
            end_page_next = PCW'(req.page_index) + PCW'(req.page_count);
            phase_next    = PH_CHECK;
            if (req.page_count == '0) begin
              res_status_next = STATUS_OK;
              state_next      = ST_DONE;
            end else if (PCW'(req.page_index) + PCW'(req.page_count)
                         > PCW'(TOTAL_PAGES)) begin
              // pages past the map are never allocated
              res_status_next = STATUS_NOT_ALLOC;
              state_next      = ST_DONE;
            end else begin
              state_next = ST_MRD;
            end
          end
        end
      end

      ST_SRD: begin
        if (pos >= limit) begin
          // end of scan closes the open run
          if (exact || better) begin
            base_next     = run_start;
            best_len_next = run_eval;
            found_next    = 1'b1;
          end
          state_next = ST_SEL;
        end else begin
          ram_re     = 1'b1;
          state_next = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (seek_used) begin
          if (used_hit[WORD_SHIFT]) begin
            run_next = '0;
            if (exact) begin
              base_next  = run_start;
              found_next = 1'b1;
              state_next = ST_SEL;
            end else begin
              if (better) begin
                base_next     = run_start;
                best_len_next = run_eval;
                found_next    = 1'b1;
              end
              if (evt_page >= limit) begin
                state_next = ST_SEL;
              end else begin
                pos_next       = evt_page + PCW'(1);
                seek_used_next = 1'b0;
                if (used_hit[WORD_SHIFT-1:0] == '1) begin
                  state_next = ST_SRD;
                end
              end
            end
          end else begin
            run_next   = run + PCW'(WORD_BITS) - PCW'(bit_off);
            pos_next   = next_word;
            state_next = ST_SRD;
          end
        end else begin
          if (free_hit[WORD_SHIFT]) begin
            pos_next       = word_base + PCW'(free_hit[WORD_SHIFT-1:0]);
            seek_used_next = 1'b1;
          end else begin
            pos_next   = next_word;
            state_next = ST_SRD;
          end
        end
      end

      ST_SEL: begin
        if (found) begin
          pos_next      = base;
          end_page_next = base + want;
          phase_next    = PH_SET;
          state_next    = ST_MRD;
        end else begin
          res_status_next = STATUS_NO_SPACE;
          state_next      = ST_DONE;
        end
      end

      ST_MRD: begin
        ram_re     = 1'b1;
        state_next = ST_MOP;
      end

      ST_MOP: begin
        case (phase)
          PH_CHECK: begin
            if ((ram_rdata & rng_mask) != rng_mask) begin
              res_status_next = STATUS_NOT_ALLOC;
              state_next      = ST_DONE;
            end else if (next_word >= end_page) begin
              // whole range is in use: second pass clears it
              phase_next = PH_CLEAR;
              pos_next   = base;
              state_next = ST_MRD;
            end else begin
              pos_next   = next_word;
              state_next = ST_MRD;
            end
          end
          PH_SET, PH_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = (phase == PH_SET) ? (ram_rdata | rng_mask)
                                          : (ram_rdata & ~rng_mask);
            if (next_word >= end_page) begin
              res_status_next = STATUS_OK;
              res_start_next  = (func_r == FUNC_ALLOC) ? base[9:0] : '0;
              state_next      = ST_DONE;
            end else begin
              pos_next   = next_word;
              state_next = ST_MRD;
            end
          end
          default: begin
            res_status_next = STATUS_NOT_ALLOC;
            state_next      = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next      = 1'b1;
          rsp_next.status     = res_status;
          rsp_next.start_page = res_start;
          state_next          = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a chosen run always lies below the scan limit
  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL && found) |-> (base + want <= limit))
    else $error("chosen run exceeds scan limit");

  // the map is only written by the clearing pass or the marking passes
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLR ||
                (state == ST_MOP && (phase == PH_SET || phase == PH_CLEAR))))
    else $error("map written outside a write pass");

  // unless a held response is stalled, a finished request reaches the output register in the next cycle
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !(rsp_valid && rsp_stall)) |=> (rsp_valid && state == ST_IDLE))
    else $error("finished request not delivered");

  // responses carry only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_NO_SPACE ||
                   rsp.status == STATUS_NOT_ALLOC))
    else $error("undefined status code");

endmodule
